// ===== hdl/gregorian_to_solar_hijri_date_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Gregorian to Solar Hijri date unit: assertion macros
// Same-cycle and next-cycle implication property wrappers with reset disable.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_TO_SOLAR_HIJRI_DATE_UNIT_MACROS_SVH
`define GREGORIAN_TO_SOLAR_HIJRI_DATE_UNIT_MACROS_SVH

// same-cycle implication
`define GSH_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSH_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gsh_pkg.sv =====
// ----------------------------------------------------------------------------
// gsh_pkg
// Widths, calendar constants and reciprocal multipliers for the date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gsh_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DAYS_W  = 20;   // absolute day count
  localparam int OFF_W   = 10;   // small day terms of the count

  localparam logic [YEAR_W-1:0] GREG_YEAR_MIN   = 12'd622;
  localparam logic [YEAR_W-1:0] EPOCH_SPLIT     = 12'd1600;
  localparam logic [YEAR_W-1:0] EPOCH_LOW       = 12'd621;
  localparam logic [YEAR_W-1:0] SOLAR_YEAR_HIGH = 12'd979;
  localparam logic [YEAR_W-1:0] LEAP4_BIAS      = 12'd3;
  localparam logic [YEAR_W-1:0] LEAP100_BIAS    = 12'd99;
  localparam logic [YEAR_W-1:0] LEAP400_BIAS    = 12'd399;
  localparam logic [YEAR_W-1:0] CYCLE33_YEARS   = 12'd33;
  localparam logic [YEAR_W-1:0] GROUP4_YEARS    = 12'd4;

  localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LEAP   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_SECOND = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;

  localparam logic [DAYS_W-1:0] DAY_OFFSET = 20'd80;

  localparam int unsigned CYCLE33_DAYS = 12053;
  localparam int unsigned GROUP4_DAYS  = 1461;
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned FIRST_HALF   = 186;
  localparam int unsigned LONG_MONTH   = 31;
  localparam int unsigned SHORT_MONTH  = 30;

  // leap corrections: exact ceil-reciprocal divide of 12-bit values
  localparam int unsigned C100_SHIFT = 20;
  localparam int unsigned C100_MUL   = ((1 << C100_SHIFT) + 99) / 100;
  localparam int unsigned C400_SHIFT = 22;
  localparam int unsigned C400_MUL   = ((1 << C400_SHIFT) + 399) / 400;
  localparam int          LMUL_W     = $clog2(C400_MUL + 1);
  localparam int          LPROD_W    = YEAR_W + LMUL_W;

  // 33-year cycle: floor reciprocal, quotient low by at most one
  localparam int          C33_MUL   = (1 << DAYS_W) / CYCLE33_DAYS;
  localparam int          Q33_W     = $clog2(C33_MUL + 1);
  localparam int          P33_W     = DAYS_W + Q33_W;
  localparam int          R33_W     = $clog2(CYCLE33_DAYS);
  localparam int          R33RAW_W  = R33_W + 1;

  // 4-year group: floor reciprocal, quotient low by at most one
  localparam int          C4_MUL    = (1 << R33_W) / GROUP4_DAYS;
  localparam int          Q4_W      = $clog2(C4_MUL + 1);
  localparam int          P4_W      = R33_W + Q4_W;
  localparam int          R4_W      = $clog2(GROUP4_DAYS);
  localparam int          R4RAW_W   = R4_W + 1;

  // day of year and month split
  localparam int          DY_W      = $clog2(YEAR_DAYS + 1);
  localparam int          MD_V_W    = $clog2(FIRST_HALF);
  localparam int unsigned MD_SHIFT  = 16;
  localparam int unsigned M31_MUL   = ((1 << MD_SHIFT) + LONG_MONTH - 1) / LONG_MONTH;
  localparam int unsigned M30_MUL   = ((1 << MD_SHIFT) + SHORT_MONTH - 1) / SHORT_MONTH;
  localparam int          MD_MUL_W  = $clog2(M30_MUL + 1);
  localparam int          MD_P_W    = MD_V_W + MD_MUL_W;
  localparam int          MD_Q_W    = MD_P_W - MD_SHIFT;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [YEAR_W-1:0] jy;
  } gsh_count_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gsh_greg_if.sv =====
// ----------------------------------------------------------------------------
// gsh_greg_if
// Gregorian date channel: valid/ready with year, month and day.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsh_greg_if;
  logic                        valid;
  logic                        ready;
  logic [gsh_pkg::YEAR_W-1:0]  greg_year;
  logic [gsh_pkg::MONTH_W-1:0] greg_month;
  logic [gsh_pkg::DAY_W-1:0]   greg_day;

  modport source (output valid, greg_year, greg_month, greg_day, input ready);
  modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
endinterface

`default_nettype wire

// ===== hdl/gsh_solar_if.sv =====
// ----------------------------------------------------------------------------
// gsh_solar_if
// Solar Hijri date channel: valid/ready with year, month and day.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsh_solar_if;
  logic                        valid;
  logic                        ready;
  logic [gsh_pkg::YEAR_W-1:0]  solar_year;
  logic [gsh_pkg::MONTH_W-1:0] solar_month;
  logic [gsh_pkg::DAY_W-1:0]   solar_day;

  modport source (output valid, solar_year, solar_month, solar_day, input ready);
  modport sink   (input valid, solar_year, solar_month, solar_day, output ready);
endinterface

`default_nettype wire

// ===== hdl/gsh_day_count.sv =====
// ----------------------------------------------------------------------------
// gsh_day_count
// Three-stage front end: input clamp, leap-day terms, absolute day count.
// ----------------------------------------------------------------------------
`default_nettype none

module gsh_day_count (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [gsh_pkg::YEAR_W-1:0]  greg_year,
  input  logic [gsh_pkg::MONTH_W-1:0] greg_month,
  input  logic [gsh_pkg::DAY_W-1:0]   greg_day,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output gsh_pkg::gsh_count_t         dn_count
);

  logic [2:0] vld_r, vld_nxt, vld_in;
  logic [3:0] en;

  // stage 1
  logic [gsh_pkg::YEAR_W-1:0]  gyc, gy, gy2;
  logic [gsh_pkg::MONTH_W-1:0] gm;
  logic                        hi;
  logic [gsh_pkg::YEAR_W-1:0]  s1_gy_nxt, s1_a_nxt, s1_b_nxt;
  logic [gsh_pkg::OFF_W-1:0]   s1_off_nxt;
  logic [gsh_pkg::YEAR_W-1:0]  s1_gy_r, s1_a_r, s1_b_r;
  logic [gsh_pkg::OFF_W-1:0]   s1_off_r;
  logic                        s1_hi_r;

  // stage 2
  logic [gsh_pkg::LPROD_W-1:0] p100, p400;
  logic [gsh_pkg::DAYS_W-1:0]  s2_y365_nxt, s2_y365_r;
  logic [gsh_pkg::LPROD_W-1:gsh_pkg::C100_SHIFT] s2_q100_nxt, s2_q100_r;
  logic [gsh_pkg::LPROD_W-1:gsh_pkg::C400_SHIFT] s2_q400_nxt, s2_q400_r;
  logic [gsh_pkg::OFF_W-1:0]   s2_off_r;
  logic                        s2_hi_r;

  // stage 3
  gsh_pkg::gsh_count_t         s3_nxt, s3_r;

  always_comb begin
    en[3] = dn_ready;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_in   = {vld_r[1:0], up_valid};
  assign up_ready = en[0];
  assign dn_valid = vld_r[2];
  assign dn_count = s3_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vld_nxt[k] = en[k] ? vld_in[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    gyc = (greg_year < gsh_pkg::GREG_YEAR_MIN) ? gsh_pkg::GREG_YEAR_MIN : greg_year;
    if (greg_month < gsh_pkg::MONTH_FIRST) begin
      gm = gsh_pkg::MONTH_FIRST;
    end else if (greg_month > gsh_pkg::MONTH_LAST) begin
      gm = gsh_pkg::MONTH_LAST;
    end else begin
      gm = greg_month;
    end
    hi  = gyc > gsh_pkg::EPOCH_SPLIT;
    gy  = hi ? gyc - gsh_pkg::EPOCH_SPLIT : gyc - gsh_pkg::EPOCH_LOW;
    gy2 = gy + gsh_pkg::YEAR_W'(gm > gsh_pkg::MONTH_LEAP);
    s1_gy_nxt  = gy;
    s1_a_nxt   = gy2 + gsh_pkg::LEAP100_BIAS;
    s1_b_nxt   = gy2 + gsh_pkg::LEAP400_BIAS;
    s1_off_nxt = gsh_pkg::OFF_W'((gy2 + gsh_pkg::LEAP4_BIAS) >> 2)
               + gsh_pkg::OFF_W'(greg_day)
               + gsh_pkg::OFF_W'(gsh_pkg::days_before_month(gm));
  end

  always_comb begin
    p100 = gsh_pkg::LPROD_W'(s1_a_r) * gsh_pkg::LPROD_W'(gsh_pkg::C100_MUL);
    p400 = gsh_pkg::LPROD_W'(s1_b_r) * gsh_pkg::LPROD_W'(gsh_pkg::C400_MUL);
    s2_q100_nxt = p100[gsh_pkg::LPROD_W-1:gsh_pkg::C100_SHIFT];
    s2_q400_nxt = p400[gsh_pkg::LPROD_W-1:gsh_pkg::C400_SHIFT];
    s2_y365_nxt = gsh_pkg::DAYS_W'(s1_gy_r) * gsh_pkg::DAYS_W'(gsh_pkg::YEAR_DAYS);
  end

  always_comb begin
    s3_nxt.days = s2_y365_r + gsh_pkg::DAYS_W'(s2_off_r) + gsh_pkg::DAYS_W'(s2_q400_r)
                - gsh_pkg::DAYS_W'(s2_q100_r) - gsh_pkg::DAY_OFFSET;
    s3_nxt.jy   = s2_hi_r ? gsh_pkg::SOLAR_YEAR_HIGH : '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_gy_r  <= s1_gy_nxt;
      s1_a_r   <= s1_a_nxt;
      s1_b_r   <= s1_b_nxt;
      s1_off_r <= s1_off_nxt;
      s1_hi_r  <= hi;
    end
    if (en[1]) begin
      s2_y365_r <= s2_y365_nxt;
      s2_q100_r <= s2_q100_nxt;
      s2_q400_r <= s2_q400_nxt;
      s2_off_r  <= s1_off_r;
      s2_hi_r   <= s1_hi_r;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gregorian_to_solar_hijri_date_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_to_solar_hijri_date_unit
// Gregorian to Solar Hijri (Jalali) date conversion, twelve-stage pipeline.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  in_greg    in   valid/ready   greg_year[11:0] greg_month[3:0] greg_day[4:0]
//  out_solar  out  valid/ready   solar_year[11:0] solar_month[3:0] solar_day[4:0]
//
//  One transaction per cycle sustained while the output is not stalled;
//  each passes through twelve register stages: three in the day count,
//  nine in the divide chain.
//  Reset clears the stage valid bits only; no clearing pass.
//  Each stage holds while its successor is full and stalled; empty stages
//  fill behind a stalled output, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gregorian_to_solar_hijri_date_unit_macros.svh"

module gregorian_to_solar_hijri_date_unit (
  input  logic         clk,
  input  logic         rst_n,
  gsh_greg_if.sink     in_greg,
  gsh_solar_if.source  out_solar
);

  logic                dc_valid, dc_ready;
  gsh_pkg::gsh_count_t dc_count;

  logic [12:4] vld_r, vld_nxt, vld_in;
  logic [13:4] en;

  // stage 4: 33-year quotient estimate
  logic [gsh_pkg::P33_W-1:0]    p33;
  logic [gsh_pkg::Q33_W-1:0]    s4_q_nxt, s4_q_r;
  logic [gsh_pkg::DAYS_W-1:0]   s4_days_r;
  logic [gsh_pkg::YEAR_W-1:0]   s4_jy_r;
  // stage 5: raw remainder
  logic [gsh_pkg::DAYS_W:0]     m33, d33;
  logic [gsh_pkg::R33RAW_W-1:0] s5_r_nxt, s5_r_r;
  logic [gsh_pkg::Q33_W-1:0]    s5_q_r;
  logic [gsh_pkg::YEAR_W-1:0]   s5_jy_r;
  // stage 6: corrected remainder, year update
  logic                         ge33;
  logic [gsh_pkg::Q33_W-1:0]    q33;
  logic [gsh_pkg::R33_W-1:0]    s6_r_nxt, s6_r_r;
  logic [gsh_pkg::YEAR_W-1:0]   s6_jy_nxt, s6_jy_r;
  // stage 7: 4-year quotient estimate
  logic [gsh_pkg::P4_W-1:0]     p4;
  logic [gsh_pkg::Q4_W-1:0]     s7_q_nxt, s7_q_r;
  logic [gsh_pkg::R33_W-1:0]    s7_r_r;
  logic [gsh_pkg::YEAR_W-1:0]   s7_jy_r;
  // stage 8
  logic [gsh_pkg::R33RAW_W-1:0] m4, d4;
  logic [gsh_pkg::R4RAW_W-1:0]  s8_r_nxt, s8_r_r;
  logic [gsh_pkg::Q4_W-1:0]     s8_q_r;
  logic [gsh_pkg::YEAR_W-1:0]   s8_jy_r;
  // stage 9
  logic                         ge4;
  logic [gsh_pkg::Q4_W-1:0]     q4;
  logic [gsh_pkg::R4_W-1:0]     s9_r_nxt, s9_r_r;
  logic [gsh_pkg::YEAR_W-1:0]   s9_jy_nxt, s9_jy_r;
  // stage 10: single years
  logic [gsh_pkg::R4_W-1:0]     t4;
  logic [1:0]                   yadd;
  logic [gsh_pkg::DY_W-1:0]     s10_dy_nxt, s10_dy_r;
  logic [gsh_pkg::YEAR_W-1:0]   s10_jy_nxt, s10_jy_r;
  // stage 11: month quotient
  logic                         s11_first_nxt, s11_first_r;
  logic [gsh_pkg::MD_V_W-1:0]   s11_v_nxt, s11_v_r;
  logic [gsh_pkg::MD_MUL_W-1:0] mdk;
  logic [gsh_pkg::MD_P_W-1:0]   pmd;
  logic [gsh_pkg::MD_Q_W-1:0]   s11_q_nxt, s11_q_r;
  logic [gsh_pkg::YEAR_W-1:0]   s11_jy_r;
  // stage 12: output register
  logic [gsh_pkg::MD_V_W-1:0]   mdiv, mrem;
  logic [gsh_pkg::MONTH_W-1:0]  s12_jm_nxt, s12_jm_r;
  logic [gsh_pkg::DAY_W-1:0]    s12_jd_nxt, s12_jd_r;
  logic [gsh_pkg::YEAR_W-1:0]   s12_jy_r;

  gsh_day_count u_day_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_greg.valid),
    .up_ready   (in_greg.ready),
    .greg_year  (in_greg.greg_year),
    .greg_month (in_greg.greg_month),
    .greg_day   (in_greg.greg_day),
    .dn_valid   (dc_valid),
    .dn_ready   (dc_ready),
    .dn_count   (dc_count)
  );

  always_comb begin
    en[13] = out_solar.ready;
    for (int k = 12; k >= 4; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign dc_ready = en[4];
  assign vld_in   = {vld_r[11:4], dc_valid};

  always_comb begin
    for (int k = 4; k <= 12; k++) begin
      vld_nxt[k] = en[k] ? vld_in[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    p33      = gsh_pkg::P33_W'(dc_count.days) * gsh_pkg::P33_W'(gsh_pkg::C33_MUL);
    s4_q_nxt = p33[gsh_pkg::P33_W-1:gsh_pkg::DAYS_W];

    m33      = (gsh_pkg::DAYS_W+1)'(s4_q_r) * (gsh_pkg::DAYS_W+1)'(gsh_pkg::CYCLE33_DAYS);
    d33      = (gsh_pkg::DAYS_W+1)'(s4_days_r) - m33;
    s5_r_nxt = d33[gsh_pkg::R33RAW_W-1:0];

    ge33      = s5_r_r >= gsh_pkg::R33RAW_W'(gsh_pkg::CYCLE33_DAYS);
    s6_r_nxt  = ge33 ? gsh_pkg::R33_W'(s5_r_r - gsh_pkg::R33RAW_W'(gsh_pkg::CYCLE33_DAYS))
                     : gsh_pkg::R33_W'(s5_r_r);
    q33       = s5_q_r + gsh_pkg::Q33_W'(ge33);
    s6_jy_nxt = s5_jy_r + gsh_pkg::YEAR_W'(q33) * gsh_pkg::CYCLE33_YEARS;

    p4       = gsh_pkg::P4_W'(s6_r_r) * gsh_pkg::P4_W'(gsh_pkg::C4_MUL);
    s7_q_nxt = p4[gsh_pkg::P4_W-1:gsh_pkg::R33_W];

    m4       = gsh_pkg::R33RAW_W'(s7_q_r) * gsh_pkg::R33RAW_W'(gsh_pkg::GROUP4_DAYS);
    d4       = gsh_pkg::R33RAW_W'(s7_r_r) - m4;
    s8_r_nxt = d4[gsh_pkg::R4RAW_W-1:0];

    ge4       = s8_r_r >= gsh_pkg::R4RAW_W'(gsh_pkg::GROUP4_DAYS);
    s9_r_nxt  = ge4 ? gsh_pkg::R4_W'(s8_r_r - gsh_pkg::R4RAW_W'(gsh_pkg::GROUP4_DAYS))
                    : gsh_pkg::R4_W'(s8_r_r);
    q4        = s8_q_r + gsh_pkg::Q4_W'(ge4);
    s9_jy_nxt = s8_jy_r + gsh_pkg::YEAR_W'(q4) * gsh_pkg::GROUP4_YEARS;
  end

  // year within the 4-year group
  always_comb begin
    t4 = s9_r_r - gsh_pkg::R4_W'(1);
    if (s9_r_r <= gsh_pkg::R4_W'(gsh_pkg::YEAR_DAYS)) begin
      yadd       = 2'd0;
      s10_dy_nxt = gsh_pkg::DY_W'(s9_r_r);
    end else if (t4 >= gsh_pkg::R4_W'(3 * gsh_pkg::YEAR_DAYS)) begin
      yadd       = 2'd3;
      s10_dy_nxt = gsh_pkg::DY_W'(t4 - gsh_pkg::R4_W'(3 * gsh_pkg::YEAR_DAYS));
    end else if (t4 >= gsh_pkg::R4_W'(2 * gsh_pkg::YEAR_DAYS)) begin
      yadd       = 2'd2;
      s10_dy_nxt = gsh_pkg::DY_W'(t4 - gsh_pkg::R4_W'(2 * gsh_pkg::YEAR_DAYS));
    end else begin
      yadd       = 2'd1;
      s10_dy_nxt = gsh_pkg::DY_W'(t4 - gsh_pkg::R4_W'(gsh_pkg::YEAR_DAYS));
    end
    s10_jy_nxt = s9_jy_r + gsh_pkg::YEAR_W'(yadd);
  end

  always_comb begin
    s11_first_nxt = s10_dy_r < gsh_pkg::DY_W'(gsh_pkg::FIRST_HALF);
    s11_v_nxt     = s11_first_nxt ? gsh_pkg::MD_V_W'(s10_dy_r)
                  : gsh_pkg::MD_V_W'(s10_dy_r - gsh_pkg::DY_W'(gsh_pkg::FIRST_HALF));
    mdk           = s11_first_nxt ? gsh_pkg::MD_MUL_W'(gsh_pkg::M31_MUL)
                                  : gsh_pkg::MD_MUL_W'(gsh_pkg::M30_MUL);
    pmd           = gsh_pkg::MD_P_W'(s11_v_nxt) * gsh_pkg::MD_P_W'(mdk);
    s11_q_nxt     = pmd[gsh_pkg::MD_P_W-1:gsh_pkg::MD_SHIFT];

    mdiv       = s11_first_r ? gsh_pkg::MD_V_W'(gsh_pkg::LONG_MONTH)
                             : gsh_pkg::MD_V_W'(gsh_pkg::SHORT_MONTH);
    mrem       = s11_v_r - gsh_pkg::MD_V_W'(s11_q_r) * mdiv;
    s12_jm_nxt = (s11_first_r ? gsh_pkg::MONTH_FIRST : gsh_pkg::MONTH_SECOND)
               + gsh_pkg::MONTH_W'(s11_q_r);
    s12_jd_nxt = gsh_pkg::DAY_W'(mrem) + gsh_pkg::DAY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_q_r    <= s4_q_nxt;
      s4_days_r <= dc_count.days;
      s4_jy_r   <= dc_count.jy;
    end
    if (en[5]) begin
      s5_r_r  <= s5_r_nxt;
      s5_q_r  <= s4_q_r;
      s5_jy_r <= s4_jy_r;
    end
    if (en[6]) begin
      s6_r_r  <= s6_r_nxt;
      s6_jy_r <= s6_jy_nxt;
    end
    if (en[7]) begin
      s7_q_r  <= s7_q_nxt;
      s7_r_r  <= s6_r_r;
      s7_jy_r <= s6_jy_r;
    end
    if (en[8]) begin
      s8_r_r  <= s8_r_nxt;
      s8_q_r  <= s7_q_r;
      s8_jy_r <= s7_jy_r;
    end
    if (en[9]) begin
      s9_r_r  <= s9_r_nxt;
      s9_jy_r <= s9_jy_nxt;
    end
    if (en[10]) begin
      s10_dy_r <= s10_dy_nxt;
      s10_jy_r <= s10_jy_nxt;
    end
    if (en[11]) begin
      s11_first_r <= s11_first_nxt;
      s11_v_r     <= s11_v_nxt;
      s11_q_r     <= s11_q_nxt;
      s11_jy_r    <= s10_jy_r;
    end
    if (en[12]) begin
      s12_jm_r <= s12_jm_nxt;
      s12_jd_r <= s12_jd_nxt;
      s12_jy_r <= s11_jy_r;
    end
  end

  assign out_solar.valid       = vld_r[12];
  assign out_solar.solar_year  = s12_jy_r;
  assign out_solar.solar_month = s12_jm_r;
  assign out_solar.solar_day   = s12_jd_r;

  `GSH_ASSERT_IMPL(a_cycle_rem, clk, rst_n, vld_r[6], s6_r_r < gsh_pkg::R33_W'(gsh_pkg::CYCLE33_DAYS), "33-year remainder out of range")
  `GSH_ASSERT_IMPL(a_group_rem, clk, rst_n, vld_r[9], s9_r_r < gsh_pkg::R4_W'(gsh_pkg::GROUP4_DAYS), "4-year remainder out of range")
  `GSH_ASSERT_IMPL(a_month_ok, clk, rst_n, vld_r[12], (s12_jm_r >= gsh_pkg::MONTH_FIRST) && (s12_jm_r <= gsh_pkg::MONTH_LAST) && (s12_jd_r != '0), "result month or day out of range")
  `GSH_ASSERT_NEXT(a_stage_hold, clk, rst_n, vld_r[8] && !en[8], vld_r[8] && $stable(s8_r_r), "stalled stage lost its transaction")

endmodule

`default_nettype wire
